[rtl/core/md5_pkg.sv]
// shared types, constants and round tables for the md5 engine
package md5_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } md5_item_t;

    localparam logic [31:0] INIT_WORDS [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // message word index used by a round
    function automatic logic [3:0] md5_g(input logic [5:0] r);
        logic [3:0] x;
        logic [3:0] g;
        x = r[3:0];
        case (r[5:4])
            2'd0:    g = x;
            2'd1:    g = (x << 2) + x + 4'd1;
            2'd2:    g = (x << 1) + x + 4'd5;
            2'd3:    g = (x << 3) - x;
            default: g = x;
        endcase
        return g;
    endfunction

    // rotate amount used by a round
    function automatic logic [4:0] md5_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0:    s = 5'd7;
            4'h1:    s = 5'd12;
            4'h2:    s = 5'd17;
            4'h3:    s = 5'd22;
            4'h4:    s = 5'd5;
            4'h5:    s = 5'd9;
            4'h6:    s = 5'd14;
            4'h7:    s = 5'd20;
            4'h8:    s = 5'd4;
            4'h9:    s = 5'd11;
            4'ha:    s = 5'd16;
            4'hb:    s = 5'd23;
            4'hc:    s = 5'd6;
            4'hd:    s = 5'd10;
            4'he:    s = 5'd15;
            4'hf:    s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/md5_queue.sv]
// short fifo between the front stage and the hash back end
module md5_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  md5_pkg::md5_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output md5_pkg::md5_item_t  head
);

    md5_pkg::md5_item_t slots [md5_pkg::Q_DEPTH];

    logic [md5_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [md5_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [md5_pkg::Q_AW:0]   cnt_reg, cnt_next;

    logic do_push;
    logic do_pop;

    assign full    = (cnt_reg == (md5_pkg::Q_AW+1)'(md5_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/md5_front.sv]
// input stage: takes beats, drops empty ones, feeds the queue
module md5_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                byte_valid,
    input  logic                message_end,
    output logic                push,
    output md5_pkg::md5_item_t  push_item,
    input  logic                q_full
);

    logic               hold_valid_reg, hold_valid_next;
    md5_pkg::md5_item_t hold_item_reg;

    logic accept;
    logic useful;

    assign in_stall  = hold_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    // a beat with no byte and no end marker changes nothing
    assign useful    = byte_valid || message_end;
    assign push      = hold_valid_reg && !q_full;
    assign push_item = hold_item_reg;

    always_comb
    begin
        if (hold_valid_reg && q_full)
        begin
            hold_valid_next = 1'b1;
        end
        else
        begin
            hold_valid_next = accept && useful;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg.data_byte   <= data_byte;
            hold_item_reg.byte_valid  <= byte_valid;
            hold_item_reg.message_end <= message_end;
        end
    end

endmodule

[rtl/core/md5_back.sv]
// back end: block buffer, padding, 64-round compression and digest output
module md5_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  md5_pkg::md5_item_t  q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         digest_word,
    output logic [1:0]          word_index,
    output logic                last_word
);

    typedef enum logic [5:0] {
        ST_ABSORB = 6'b000001,
        ST_PREF0  = 6'b000010,
        ST_PREF1  = 6'b000100,
        ST_ROUND  = 6'b001000,
        ST_FOLD   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        PH_DATA = 4'b0001,
        PH_PAD  = 4'b0010,
        PH_ZERO = 4'b0100,
        PH_LEN  = 4'b1000
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [60:0] count_reg, count_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] wbuf_reg, wbuf_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] pre_reg, pre_next;
    logic [5:0]  round_reg, round_next;
    logic [1:0]  emit_idx_reg, emit_idx_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] digest_word_reg, digest_word_next;
    logic [1:0]  word_index_reg, word_index_next;
    logic        last_word_reg, last_word_next;

    logic [31:0] mem [16];
    logic [31:0] rdata_reg;
    logic [3:0]  raddr;
    logic        mem_we;
    logic [31:0] wdata;

    logic        absorb_en;
    logic [7:0]  absorb_byte;
    logic [5:0]  pos;
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [63:0] rot_dbl;
    logic [31:0] rot_val;
    logic [5:0]  round_p1;
    logic        out_load;

    assign pos         = count_reg[5:0];
    assign round_p1    = round_reg + 6'd1;
    assign out_load    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign digest_word = digest_word_reg;
    assign word_index  = word_index_reg;
    assign last_word   = last_word_reg;

    // round datapath
    always_comb
    begin
        case (round_reg[5:4])
            2'd0:    f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1:    f_val = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            2'd3:    f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
        t_val   = pre_reg + f_val;
        rot_dbl = {t_val, t_val} << md5_pkg::md5_s(round_reg);
        rot_val = rot_dbl[63:32];
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        count_next       = count_reg;
        bits_next        = bits_reg;
        wbuf_next        = wbuf_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        c_next           = c_reg;
        d_next           = d_reg;
        pre_next         = pre_reg;
        round_next       = round_reg;
        emit_idx_next    = emit_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        digest_word_next = digest_word_reg;
        word_index_next  = word_index_reg;
        last_word_next   = last_word_reg;
        for (int k = 0; k < 4; k++)
        begin
            chain_next[k] = chain_reg[k];
        end
        q_pop       = 1'b0;
        absorb_en   = 1'b0;
        absorb_byte = 8'h00;
        mem_we      = 1'b0;
        wdata       = {absorb_byte, wbuf_reg[23:0]};
        // reads run two rounds ahead of the round that uses them
        raddr       = md5_pkg::md5_g(round_reg + 6'd2);

        case (state_reg)
            ST_ABSORB:
            begin
                case (phase_reg)
                    PH_DATA:
                    begin
                        if (!q_empty)
                        begin
                            q_pop       = 1'b1;
                            absorb_en   = q_head.byte_valid;
                            absorb_byte = q_head.data_byte;
                            if (q_head.message_end)
                            begin
                                phase_next = PH_PAD;
                                bits_next  = {count_reg + 61'(q_head.byte_valid), 3'b000};
                            end
                        end
                    end
                    PH_PAD:
                    begin
                        absorb_en   = 1'b1;
                        absorb_byte = md5_pkg::PAD_BYTE;
                        phase_next  = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (pos == md5_pkg::LEN_POS)
                        begin
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            absorb_en = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        absorb_en   = 1'b1;
                        absorb_byte = bits_reg[{pos[2:0], 3'b000} +: 8];
                    end
                    default:
                    begin
                        phase_next = PH_DATA;
                    end
                endcase

                if (absorb_en)
                begin
                    case (pos[1:0])
                        2'd0:    wbuf_next[7:0]   = absorb_byte;
                        2'd1:    wbuf_next[15:8]  = absorb_byte;
                        2'd2:    wbuf_next[23:16] = absorb_byte;
                        2'd3:    wbuf_next[31:24] = absorb_byte;
                        default: wbuf_next[7:0]   = absorb_byte;
                    endcase
                    wdata      = {absorb_byte, wbuf_reg[23:0]};
                    mem_we     = (pos[1:0] == 2'd3);
                    count_next = count_reg + 61'd1;
                    if (pos == md5_pkg::LAST_POS)
                    begin
                        state_next = ST_PREF0;
                    end
                end
            end
            ST_PREF0:
            begin
                raddr      = md5_pkg::md5_g(6'd0);
                state_next = ST_PREF1;
            end
            ST_PREF1:
            begin
                raddr      = md5_pkg::md5_g(6'd1);
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                pre_next   = chain_reg[0] + md5_pkg::K_TAB[0] + rdata_reg;
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                a_next     = d_reg;
                b_next     = b_reg + rot_val;
                c_next     = b_reg;
                d_next     = c_reg;
                // next round's a is this round's d
                pre_next   = d_reg + md5_pkg::K_TAB[round_p1] + rdata_reg;
                round_next = round_p1;
                if (round_reg == md5_pkg::LAST_POS)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (phase_reg == PH_LEN)
                begin
                    state_next    = ST_EMIT;
                    emit_idx_next = 2'd0;
                end
                else
                begin
                    state_next = ST_ABSORB;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    digest_word_next = chain_reg[emit_idx_reg];
                    word_index_next  = emit_idx_reg;
                    last_word_next   = (emit_idx_reg == 2'd3);
                    emit_idx_next    = emit_idx_reg + 2'd1;
                    if (emit_idx_reg == 2'd3)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            chain_next[k] = md5_pkg::INIT_WORDS[k];
                        end
                        count_next = '0;
                        phase_next = PH_DATA;
                        state_next = ST_ABSORB;
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ABSORB;
            phase_reg     <= PH_DATA;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            emit_idx_reg  <= '0;
            round_reg     <= '0;
            for (int k = 0; k < 4; k++)
            begin
                chain_reg[k] <= md5_pkg::INIT_WORDS[k];
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            emit_idx_reg  <= emit_idx_next;
            round_reg     <= round_next;
            for (int k = 0; k < 4; k++)
            begin
                chain_reg[k] <= chain_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg        <= bits_next;
        wbuf_reg        <= wbuf_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        c_reg           <= c_next;
        d_reg           <= d_next;
        pre_reg         <= pre_next;
        digest_word_reg <= digest_word_next;
        word_index_reg  <= word_index_next;
        last_word_reg   <= last_word_next;
    end

    // block buffer, one 32-bit message word per entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos[5:2]] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

[rtl/core/md5_hash_engine_unit.sv]
// md5 engine top level: front stage, queue and hash back end
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  data_byte, byte_valid, message_end
//  out      from block out_valid / out_stall digest_word, word_index, last_word
//
// one message byte per cycle while gathering from a non-empty queue; each full
// 64-byte block then holds the back end: two read setup, 64 rounds, one fold
// message end adds the padding bytes at one per cycle, their compressions,
// and four digest beats; the front keeps taking beats until the queue is full
// reset restores the initial chaining words and clears the byte count; no
// clearing pass; a stalled output holds its beat and the digest waits behind it
module md5_hash_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    logic               push;
    md5_pkg::md5_item_t push_item;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    md5_pkg::md5_item_t q_head;

    md5_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .message_end (message_end),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    md5_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    md5_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

[tb/testbench.sv]
// self-checking testbench for the md5 hash engine with a digest scoreboard
module testbench;

    localparam int CLK_PERIOD   = 12;
    localparam int ITEM_TARGET  = 420;
    localparam int QUIET_AFTER  = ITEM_TARGET - 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    localparam bit [31:0] IV_WORDS [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam bit [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct {
        bit [31:0] word;
        bit [1:0]  index;
        bit        last;
    } digest_beat_t;

    class md5_scoreboard;
        bit [31:0]    chain [4];
        bit [7:0]     block [64];
        bit [60:0]    nbytes;
        digest_beat_t digest_q [$];
        int           fails;
        int           digests_expected;

        function new();
            fails = 0;
            digests_expected = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 4; i++)
                chain[i] = IV_WORDS[i];
            nbytes = '0;
        endfunction

        function bit [31:0] rotl(bit [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void compress();
            bit [31:0] m [16];
            bit [31:0] a, b, c, d, f, t;
            int        g;
            for (int i = 0; i < 16; i++)
                m[i] = {block[4*i+3], block[4*i+2], block[4*i+1], block[4*i]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++)
            begin
                if (i < 16)
                begin
                    f = d ^ (b & (c ^ d));
                    g = i;
                end
                else if (i < 32)
                begin
                    f = c ^ (d & (b ^ c));
                    g = (5 * i + 1) & 15;
                end
                else if (i < 48)
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) & 15;
                end
                else
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) & 15;
                end
                t = d;
                d = c;
                c = b;
                b = b + rotl(a + f + SINE_K[i] + m[g], ROT_AMT[(i >> 4) * 4 + (i & 3)]);
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void absorb(bit [7:0] v);
            bit [5:0] pos;
            pos = nbytes[5:0];
            block[pos] = v;
            nbytes = nbytes + 61'd1;
            if (pos == 6'd63)
                compress();
        endfunction

        // one accepted input beat; a message end queues the four digest words
        function void note_input(bit [7:0] data, bit has_byte, bit is_end);
            bit [63:0]    bitlen;
            digest_beat_t beat;
            if (has_byte)
                absorb(data);
            if (!is_end)
                return;
            bitlen = {nbytes, 3'b000};
            absorb(8'h80);
            while (nbytes[5:0] != 6'd56)
                absorb(8'h00);
            for (int i = 0; i < 8; i++)
                absorb(bitlen[8*i +: 8]);
            for (int i = 0; i < 4; i++)
            begin
                beat.word  = chain[i];
                beat.index = i[1:0];
                beat.last  = (i == 3);
                digest_q.push_back(beat);
                digests_expected++;
            end
            restart();
        endfunction

        function void check_result(bit [31:0] word, bit [1:0] index, bit last);
            digest_beat_t exp_beat;
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest beat: word %h index %0d last %0d",
                       word, index, last);
                fails++;
                return;
            end
            exp_beat = digest_q.pop_front();
            if (word !== exp_beat.word)
            begin
                $error("digest_word: expected %h, actual %h", exp_beat.word, word);
                fails++;
            end
            if (index !== exp_beat.index)
            begin
                $error("word_index: expected %0d, actual %0d", exp_beat.index, index);
                fails++;
            end
            if (last !== exp_beat.last)
            begin
                $error("last_word: expected %0d, actual %0d", exp_beat.last, last);
                fails++;
            end
        endfunction

        function int outstanding();
            return digest_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        message_end;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    md5_scoreboard sb;
    int            items_sent;
    int            cycles;
    bit            quiet;
    bit            hold_req;

    md5_hash_engine_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .message_end (message_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(digest_word, word_index, last_word);
    end

    // receiver: random stall bursts, calm stretches and one long hold-off
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                n = $urandom_range(1, 17);
                repeat (n - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 19) == 0)
            begin
                out_stall = 1'b0;
                n = $urandom_range(20, 80);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input bit [7:0] data, input bit has_byte, input bit is_end);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            n = $urandom_range(1, 17);
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    = 1'b1;
        data_byte   = data;
        byte_valid  = has_byte;
        message_end = is_end;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(data, has_byte, is_end);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        bit tail_byte;
        tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(pick_byte(), 1'b0, 1'b0);
            send_item(pick_byte(), 1'b1, tail_byte && (i == len - 1));
        end
        if (!tail_byte)
            send_item(pick_byte(), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int len;
        sb          = new();
        items_sent  = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        byte_valid  = 1'b0;
        message_end = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty message, then a beat that carries nothing
        send_item(8'h3c, 1'b0, 1'b1);
        send_item(8'ha5, 1'b0, 1'b0);
        // single bytes at the extremes, each ending its message
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        // "abc" closed by a bare end marker
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // empty beat in the middle of a message
        send_item(8'h78, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h79, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        // back-to-back empty messages
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'haa, 1'b0, 1'b1);
        wait_drained();

        // long output hold-off while input keeps coming, so the queue backs up
        hold_req = 1'b1;
        send_message(3);
        send_message(2);
        send_message(40);
        send_message(1);
        wait_drained();

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_AFTER)
                quiet = 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:  len = $urandom_range(0, 8);
                6, 7, 8, 9, 10:    len = $urandom_range(53, 57);
                11, 12, 13:        len = $urandom_range(62, 66);
                14:                len = $urandom_range(118, 130);
                default:           len = $urandom_range(0, 40);
            endcase
            // keep the run close to its item budget
            if (items_sent + len > ITEM_TARGET + 20)
                len = $urandom_range(0, 12);
            send_message(len);
            if ($urandom_range(0, 9) == 0)
                send_item(pick_byte(), 1'b0, 1'b0);
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
